// File: sv/bfsa_pkg.sv
`default_nettype none
package bfsa_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int ADDR_WIDTH_DEF   = 24;
   localparam int ALIGN_WIDTH      = 12;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 3;
   localparam int HEAP_RESET       = 65536;
   localparam int ALIGN_RESET      = 3;

   localparam logic REG_HEAP_SIZE  = 1'b0;
   localparam logic REG_ALIGN_MASK = 1'b1;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [2:0] STAT_OK           = 3'd0;
   localparam logic [2:0] STAT_NO_FIT       = 3'd1;
   localparam logic [2:0] STAT_FULL         = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND    = 3'd3;
   localparam logic [2:0] STAT_ALREADY_FREE = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_SCAN,
      S_DECIDE,
      S_MOVE,
      S_COMMIT,
      S_COMMIT2,
      S_RESP
   } bfsa_state_type;

   typedef struct packed {
      logic init;
      logic load;
      logic scan;
      logic decide;
      logic move;
      logic commit;
      logic commit2;
   } bfsa_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic decide_ok;
      logic move_done;
   } bfsa_stat_type;

endpackage
`default_nettype wire

// File: sv/bfsa_req_if.sv
`default_nettype none
interface bfsa_req_if #(parameter int ADDR_WIDTH = 24);
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [ADDR_WIDTH-1:0] request_size;
   logic [ADDR_WIDTH-1:0] release_address;

   modport source (output valid, command, request_size, release_address, input ready);
   modport sink   (input valid, command, request_size, release_address, output ready);
endinterface
`default_nettype wire

// File: sv/bfsa_rsp_if.sv
`default_nettype none
interface bfsa_rsp_if #(parameter int ADDR_WIDTH = 24);
   logic                  valid;
   logic                  ready;
   logic [ADDR_WIDTH-1:0] granted_address;
   logic [2:0]            status;

   modport source (output valid, granted_address, status, input ready);
   modport sink   (input valid, granted_address, status, output ready);
endinterface
`default_nettype wire

// File: sv/bfsa_ctrl.sv
`default_nettype none
module bfsa_ctrl
   import bfsa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cfg_write,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire bfsa_stat_type stat,
   output bfsa_cmd_type       cmd
);

   bfsa_state_type state_ff, state_in;
   logic           init_pend_ff, init_pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         init_pend_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         init_pend_ff <= init_pend_in;
      end
   end

   always_comb begin
      init_pend_in = init_pend_ff;
      if (cfg_write) begin
         init_pend_in = 1'b1;
      end else if (state_ff == S_INIT) begin
         init_pend_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (init_pend_ff) begin
               state_in = S_INIT;
            end else if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_INIT:    state_in = S_IDLE;
         S_SCAN: begin
            if (stat.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE:  state_in = stat.decide_ok ? S_MOVE : S_RESP;
         S_MOVE: begin
            if (stat.move_done) state_in = S_COMMIT;
         end
         S_COMMIT:  state_in = S_COMMIT2;
         S_COMMIT2: state_in = S_RESP;
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !init_pend_ff;
            cmd.load  = req_valid && !init_pend_ff;
         end
         S_INIT:    cmd.init    = 1'b1;
         S_SCAN:    cmd.scan    = 1'b1;
         S_DECIDE:  cmd.decide  = 1'b1;
         S_MOVE:    cmd.move    = 1'b1;
         S_COMMIT:  cmd.commit  = 1'b1;
         S_COMMIT2: cmd.commit2 = 1'b1;
         S_RESP:    rsp_valid   = 1'b1;
         default:   cmd         = '0;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_SCAN)
      else $error("accepted word did not start a scan");
   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      init_pend_ff |-> !req_ready)
      else $error("word accepted before table init");
   a_fail_skips: assert property (@(posedge clock) disable iff (reset)
      cmd.decide && !stat.decide_ok |=> state_ff == S_RESP)
      else $error("failed command touched the table");
`endif

endmodule
`default_nettype wire

// File: sv/bfsa_datapath.sv
`default_nettype none
module bfsa_datapath
   import bfsa_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bfsa_cmd_type           cmd,
   output bfsa_stat_type               stat,
   input  wire logic                   req_command,
   input  wire logic [ADDR_WIDTH-1:0]  req_size,
   input  wire logic [ADDR_WIDTH-1:0]  req_address,
   input  wire logic [ADDR_WIDTH-1:0]  heap_size,
   input  wire logic [ALIGN_WIDTH-1:0] align_mask,
   output logic [ADDR_WIDTH-1:0]       rsp_granted,
   output logic [2:0]                  rsp_status
);

   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int LW = ADDR_WIDTH + 1;
   localparam int EW = ADDR_WIDTH + LW + 1;

   logic [EW-1:0] table_mem [MAX_SEGMENTS];
   logic [EW-1:0] rd_data_ff;

   logic [CW-1:0]         count_ff, count_in;
   logic                  op_ff;
   logic [LW-1:0]         size_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic                  vld_ff;
   logic [IW-1:0]         idx_ff;

   logic                  found_ff, hit_used_ff, run_open_ff;
   logic [IW-1:0]         best_ff, first_ff, last_ff;
   logic [LW-1:0]         best_len_ff;
   logic [ADDR_WIDTH-1:0] best_start_ff;
   logic                  prev_used_ff;
   logic [LW-1:0]         prev_len_ff;
   logic [ADDR_WIDTH-1:0] prev_start_ff;

   logic                  split_ff;
   logic [CW-1:0]         shift_ff, remain_ff;
   logic                  wr_pend_ff;
   logic [IW-1:0]         wr_addr_ff;

   logic [ADDR_WIDTH-1:0] ent_start;
   logic [LW-1:0]         ent_len;
   logic                  ent_used;
   logic                  prev_free;
   logic                  split_w;
   logic [2:0]            status_w;
   logic [CW-1:0]         n_w;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;

   assign ent_used  = rd_data_ff[0];
   assign ent_len   = rd_data_ff[LW:1];
   assign ent_start = rd_data_ff[EW-1:LW+1];
   assign prev_free = (idx_ff != '0) && !prev_used_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem[ptr_ff[IW-1:0]];
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   // outcome once the scan has seen every entry
   always_comb begin
      split_w  = best_len_ff != size_ff;
      n_w      = CW'(last_ff) - CW'(first_ff);
      status_w = STAT_OK;
      if (op_ff == CMD_ALLOC) begin
         if (!found_ff) begin
            status_w = STAT_NO_FIT;
         end else if (split_w && count_ff == CW'(MAX_SEGMENTS)) begin
            status_w = STAT_FULL;
         end
      end else begin
         if (!found_ff) begin
            status_w = STAT_NOT_FOUND;
         end else if (!hit_used_ff) begin
            status_w = STAT_ALREADY_FREE;
         end
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      priority if (cmd.init) begin
         wr_en   = 1'b1;
         wr_data = {ADDR_WIDTH'(0), LW'(heap_size), 1'b0};
      end else if (wr_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = wr_addr_ff;
         wr_data = rd_data_ff;
      end else if (cmd.commit) begin
         wr_en = 1'b1;
         if (op_ff == CMD_ALLOC) begin
            wr_addr = best_ff;
            wr_data = {best_start_ff, size_ff, 1'b1};
         end else begin
            wr_addr = first_ff;
            wr_data = {best_start_ff, best_len_ff, 1'b0};
         end
      end else if (cmd.commit2) begin
         wr_en   = (op_ff == CMD_ALLOC) && split_ff;
         wr_addr = IW'(CW'(best_ff) + CW'(1));
         wr_data = {best_start_ff + size_ff[ADDR_WIDTH-1:0], best_len_ff - size_ff, 1'b0};
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.init) begin
         count_in = CW'(1);
      end else if (cmd.commit) begin
         if (op_ff == CMD_ALLOC) begin
            count_in = count_ff + CW'(split_ff);
         end else begin
            count_in = count_ff - shift_ff;
         end
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.scan && ptr_ff < count_ff) begin
         ptr_in = ptr_ff + CW'(1);
      end else if (cmd.decide) begin
         ptr_in = (op_ff == CMD_ALLOC) ? count_ff - CW'(1) : CW'(last_ff) + CW'(1);
      end else if (cmd.move && remain_ff != '0) begin
         ptr_in = (op_ff == CMD_ALLOC) ? ptr_ff - CW'(1) : ptr_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= CW'(1);
         ptr_ff     <= '0;
         vld_ff     <= 1'b0;
         wr_pend_ff <= 1'b0;
         remain_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         ptr_ff     <= ptr_in;
         vld_ff     <= cmd.scan && (ptr_ff < count_ff);
         wr_pend_ff <= cmd.move && (remain_ff != '0);
         if (cmd.decide) begin
            if (op_ff == CMD_ALLOC) begin
               remain_ff <= split_w ? count_ff - CW'(best_ff) - CW'(1) : '0;
            end else begin
               remain_ff <= (n_w != '0) ? count_ff - CW'(last_ff) - CW'(1) : '0;
            end
         end else if (cmd.move && remain_ff != '0) begin
            remain_ff <= remain_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= ptr_ff[IW-1:0];
      if (cmd.move && remain_ff != '0) begin
         wr_addr_ff <= (op_ff == CMD_ALLOC) ? IW'(ptr_ff + CW'(1)) : IW'(ptr_ff - shift_ff);
      end
      if (cmd.load) begin
         op_ff       <= req_command;
         addr_ff     <= req_address;
         size_ff     <= (LW'(req_size) + LW'(align_mask)) & ~LW'(align_mask);
         found_ff    <= 1'b0;
         run_open_ff <= 1'b0;
      end
      if (vld_ff) begin
         prev_used_ff  <= ent_used;
         prev_len_ff   <= ent_len;
         prev_start_ff <= ent_start;
         if (op_ff == CMD_ALLOC) begin
            if (!ent_used && ent_len >= size_ff && (!found_ff || ent_len < best_len_ff)) begin
               found_ff      <= 1'b1;
               best_ff       <= idx_ff;
               best_len_ff   <= ent_len;
               best_start_ff <= ent_start;
            end
         end else if (!found_ff) begin
            if (ent_start == addr_ff) begin
               found_ff      <= 1'b1;
               hit_used_ff   <= ent_used;
               run_open_ff   <= 1'b1;
               last_ff       <= idx_ff;
               first_ff      <= prev_free ? idx_ff - IW'(1) : idx_ff;
               best_start_ff <= prev_free ? prev_start_ff : ent_start;
               best_len_ff   <= (prev_free ? prev_len_ff : LW'(0)) + ent_len;
            end
         end else if (run_open_ff) begin
            // extend the free run that follows the hit
            if (!ent_used) begin
               last_ff     <= idx_ff;
               best_len_ff <= best_len_ff + ent_len;
            end else begin
               run_open_ff <= 1'b0;
            end
         end
      end
      if (cmd.decide) begin
         split_ff    <= split_w;
         shift_ff    <= n_w;
         rsp_status  <= status_w;
         rsp_granted <= (op_ff == CMD_ALLOC && status_w == STAT_OK) ? best_start_ff : '0;
      end
   end

   assign stat.scan_done = (ptr_ff == count_ff) && !vld_ff;
   assign stat.decide_ok = status_w == STAT_OK;
   assign stat.move_done = (remain_ff == '0) && !wr_pend_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(1) && count_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count out of range");
   a_split_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && op_ff == CMD_ALLOC && split_ff |=> count_ff == $past(count_ff) + CW'(1))
      else $error("split did not add a segment");
   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CW'(wr_addr) <= count_ff)
      else $error("table write beyond the segment count");
`endif

endmodule
`default_nettype wire

// File: sv/best_fit_segment_allocator.sv
`default_nettype none
// Channel   Dir  Payload                                      Accepted at
// req_ch    in   command, request_size, release_address       valid & ready
// rsp_ch    out  granted_address, status                      valid & ready
// csr_*     in   heap_size @0x0, align_mask @0x4 (APB write)  psel & penable & pwrite
//
// One command at a time: from acceptance the block scans the segment table (single read
// port), decides, moves any entries that shift on a split or merge, writes back and
// returns the result. A failed command skips move and write-back.
// After reset and after every register write the table is rebuilt before the next
// command is accepted.
// A stalled result holds the block until rsp_ch.ready is seen.
module best_fit_segment_allocator
   import bfsa_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   bfsa_req_if.sink                   req_ch,
   bfsa_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [ADDR_WIDTH-1:0]  heap_size_ff;
   logic [ALIGN_WIDTH-1:0] align_mask_ff;
   logic                   cfg_write;
   bfsa_cmd_type           cmd;
   bfsa_stat_type          stat;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_size_ff  <= ADDR_WIDTH'(HEAP_RESET);
         align_mask_ff <= ALIGN_WIDTH'(ALIGN_RESET);
      end else if (cfg_write) begin
         if (csr_paddr[2] == REG_HEAP_SIZE) begin
            heap_size_ff <= csr_pwdata[ADDR_WIDTH-1:0];
         end else begin
            align_mask_ff <= csr_pwdata[ALIGN_WIDTH-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ALIGN_MASK) ? CSR_DATA_W'(align_mask_ff)
                                                        : CSR_DATA_W'(heap_size_ff);

   bfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (cfg_write),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfsa_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_command (req_ch.command),
      .req_size    (req_ch.request_size),
      .req_address (req_ch.release_address),
      .heap_size   (heap_size_ff),
      .align_mask  (align_mask_ff),
      .rsp_granted (rsp_ch.granted_address),
      .rsp_status  (rsp_ch.status)
   );

endmodule
`default_nettype wire
